// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ID_FIELD_W   = 16;
    localparam int TYPE_W       = 8;
    localparam int PRIO_FIELD_W = 16;
    localparam int STATUS_W     = 3;
    localparam int OCC_W        = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DUP   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NULL  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD_NEW,
        OP_FROM_PREV,
        OP_FROM_NEXT
    } t_cell_op;

    typedef struct packed {
        logic     compare;
        t_cell_op op;
    } t_cell_ctl;

    typedef struct packed {
        logic gt;
        logic match;
    } t_cell_flags;

    typedef struct packed {
        logic                            action;
        logic [ID_FIELD_W-1:0]           item_id;
        logic [TYPE_W-1:0]               item_type;
        logic signed [PRIO_FIELD_W-1:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]             status;
        logic [ID_FIELD_W-1:0]           out_item;
        logic [TYPE_W-1:0]               out_type;
        logic signed [PRIO_FIELD_W-1:0]  out_priority;
        logic [OCC_W-1:0]                occupancy;
    } t_out_item;

endpackage

// File: design/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface spq_req_if;
    import spq_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the
// pending request and loads from a neighbour or the request.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int ID_W   = 16,
    parameter int PRIO_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic [ID_W-1:0]          i_new_id,
    input  logic [TYPE_W-1:0]        i_new_type,
    input  logic signed [PRIO_W-1:0] i_new_prio,
    input  logic                     i_prev_valid,
    input  logic [ID_W-1:0]          i_prev_id,
    input  logic [TYPE_W-1:0]        i_prev_type,
    input  logic signed [PRIO_W-1:0] i_prev_prio,
    input  logic                     i_next_valid,
    input  logic [ID_W-1:0]          i_next_id,
    input  logic [TYPE_W-1:0]        i_next_type,
    input  logic signed [PRIO_W-1:0] i_next_prio,
    output logic                     o_valid,
    output logic [ID_W-1:0]          o_id,
    output logic [TYPE_W-1:0]        o_type,
    output logic signed [PRIO_W-1:0] o_prio,
    output t_cell_flags              o_flags
);

    logic                     r_valid, n_valid;
    logic [ID_W-1:0]          r_id, n_id;
    logic [TYPE_W-1:0]        r_type, n_type;
    logic signed [PRIO_W-1:0] r_prio, n_prio;
    t_cell_flags              r_flags, n_flags;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_type  = r_type;
        n_prio  = r_prio;
        case (i_ctl.op)
            OP_HOLD: begin
            end
            OP_LOAD_NEW: begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_type  = i_new_type;
                n_prio  = i_new_prio;
            end
            OP_FROM_PREV: begin
                n_valid = i_prev_valid;
                n_id    = i_prev_id;
                n_type  = i_prev_type;
                n_prio  = i_prev_prio;
            end
            OP_FROM_NEXT: begin
                n_valid = i_next_valid;
                n_id    = i_next_id;
                n_type  = i_next_type;
                n_prio  = i_next_prio;
            end
            default: begin
            end
        endcase

        n_flags = r_flags;
        if (i_ctl.compare) begin
            n_flags.gt    = !r_valid || (r_prio > i_new_prio);
            n_flags.match = r_valid && (r_id == i_new_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_type  <= n_type;
        r_prio  <= n_prio;
        r_flags <= n_flags;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_type  = r_type;
    assign o_prio  = r_prio;
    assign o_flags = r_flags;

endmodule

// File: design/stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue in ascending priority order, FIFO among equals.
//
// i_req carries one operation per item: insert (id, type, signed priority)
// or remove of the head entry. o_rsp returns exactly one item per request
// with a status code, the removed entry (zero on insert or failure) and the
// occupancy after the operation.
// Entries sit in a chain of CAPACITY cells kept sorted. A request is
// registered, then every cell compares it with its own entry in the same
// cycle and stores the result, then the chain shifts one place (towards the
// tail for an insert, towards the head for a remove) and the response is
// registered. The unit passes from S_IDLE through S_CMP to S_EXEC; a new
// request is taken only in S_IDLE, once the shift step of the last one is
// done, so requests do not overlap in the cell chain.
// Reset clears the cell valid bits and the count: the queue starts empty.
// A stalled o_rsp holds its item; the next request is still accepted and
// waits at the shift step until the response register is free.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_req_if.sink       i_req,
    spq_rsp_if.source     o_rsp
);

    localparam int ID_W   = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
    localparam int PRIO_W = (PRIO_BITS < PRIO_FIELD_W) ? PRIO_BITS : PRIO_FIELD_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    t_state                   r_state, n_state;
    t_in_item                 r_req;
    logic [CNT_W-1:0]         r_count, n_count;
    t_out_item                r_rsp, n_rsp;
    logic                     r_rsp_valid;

    logic [ID_W-1:0]          w_new_id;
    logic signed [PRIO_W-1:0] w_new_prio;

    logic [CAPACITY-1:0]      w_valid;
    logic [ID_W-1:0]          w_id   [CAPACITY];
    logic [TYPE_W-1:0]        w_type [CAPACITY];
    logic signed [PRIO_W-1:0] w_prio [CAPACITY];
    t_cell_flags              w_flags [CAPACITY];
    t_cell_ctl                w_ctl  [CAPACITY];
    logic [CAPACITY-1:0]      w_gt, w_gt_prev, w_match;

    logic w_go, w_null, w_dup, w_full, w_empty, w_do_ins, w_do_rem;
    logic [STATUS_W-1:0] w_status;

    assign w_new_id   = r_req.item_id[ID_W-1:0];
    assign w_new_prio = signed'(r_req.priority_req[PRIO_W-1:0]);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                     w_pv, w_nv;
            logic [ID_W-1:0]          w_pid, w_nid;
            logic [TYPE_W-1:0]        w_pty, w_nty;
            logic signed [PRIO_W-1:0] w_ppr, w_npr;

            if (g == 0) begin : g_head
                assign w_pv  = 1'b0;
                assign w_pid = '0;
                assign w_pty = '0;
                assign w_ppr = '0;
            end else begin : g_mid
                assign w_pv  = w_valid[g-1];
                assign w_pid = w_id[g-1];
                assign w_pty = w_type[g-1];
                assign w_ppr = w_prio[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_nv  = 1'b0;
                assign w_nid = '0;
                assign w_nty = '0;
                assign w_npr = '0;
            end else begin : g_body
                assign w_nv  = w_valid[g+1];
                assign w_nid = w_id[g+1];
                assign w_nty = w_type[g+1];
                assign w_npr = w_prio[g+1];
            end

            spq_cell #(
                .ID_W   (ID_W),
                .PRIO_W (PRIO_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl[g]),
                .i_new_id     (w_new_id),
                .i_new_type   (r_req.item_type),
                .i_new_prio   (w_new_prio),
                .i_prev_valid (w_pv),
                .i_prev_id    (w_pid),
                .i_prev_type  (w_pty),
                .i_prev_prio  (w_ppr),
                .i_next_valid (w_nv),
                .i_next_id    (w_nid),
                .i_next_type  (w_nty),
                .i_next_prio  (w_npr),
                .o_valid      (w_valid[g]),
                .o_id         (w_id[g]),
                .o_type       (w_type[g]),
                .o_prio       (w_prio[g]),
                .o_flags      (w_flags[g])
            );

            assign w_gt[g]    = w_flags[g].gt;
            assign w_match[g] = w_flags[g].match;
        end
    endgenerate

    assign w_gt_prev = {w_gt[CAPACITY-2:0], 1'b0};

    assign w_null  = (w_new_id == '0);
    assign w_dup   = |w_match;
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_go    = (r_state == S_EXEC) && (!r_rsp_valid || o_rsp.ready);

    always_comb begin
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        if (r_req.action == ACT_INSERT) begin
            if (w_null) begin
                w_status = STAT_NULL;
            end else if (w_dup) begin
                w_status = STAT_DUP;
            end else if (w_full) begin
                w_status = STAT_FULL;
            end else begin
                w_status = STAT_OK;
                w_do_ins = 1'b1;
            end
        end else begin
            if (w_empty) begin
                w_status = STAT_EMPTY;
            end else begin
                w_status = STAT_OK;
                w_do_rem = 1'b1;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        i_req.ready   = 1'b0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_ctl[k].compare = (r_state == S_CMP);
            w_ctl[k].op      = OP_HOLD;
            if (w_go && w_do_ins) begin
                if (w_gt[k] && w_gt_prev[k]) begin
                    w_ctl[k].op = OP_FROM_PREV;
                end else if (w_gt[k]) begin
                    w_ctl[k].op = OP_LOAD_NEW;
                end
            end else if (w_go && w_do_rem) begin
                w_ctl[k].op = OP_FROM_NEXT;
            end
        end
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_go && w_do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_go && w_do_rem) begin
            n_count = r_count - CNT_W'(1);
        end

        n_rsp.status       = w_status;
        n_rsp.out_item     = w_do_rem ? ID_FIELD_W'(w_id[0]) : '0;
        n_rsp.out_type     = w_do_rem ? w_type[0] : '0;
        n_rsp.out_priority = w_do_rem ? PRIO_FIELD_W'(w_prio[0]) : '0;
        n_rsp.occupancy    = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_go) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.payload;
        end
        if (w_go) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_valid[0] && (w_prio[0] <= w_prio[1])))
        else $error("head entries out of order");

    a_rsp_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (r_rsp_valid && (r_state == S_IDLE)))
        else $error("response not registered after shift");

endmodule
